// ===== rtl/hsps_pkg.sv =====
package hsps_pkg;

  // Shared divider geometry: the interpolation dividend is |speed| * 3 * step timer.
  localparam int DIV_N_W = 33;
  localparam int DIV_D_W = 20;

  typedef struct packed {
    logic load;      // capture the input beat
    logic eval;      // sector decode, debounce, position update
    logic prep;      // filtered speed when no step was taken
    logic start;     // launch the divider
    logic fin;       // speed on a step, angle, result capture
    logic out_load;  // move the result into the output register
  } hsps_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } hsps_stat_t;

endpackage

// ===== rtl/hsps_div.sv =====
module hsps_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hsps_pkg::DIV_N_W-1:0]  dividend,
  input  logic [hsps_pkg::DIV_D_W-1:0]  divisor,
  output logic [hsps_pkg::DIV_N_W-1:0]  quotient,
  output logic                          done
);

  localparam int NW    = hsps_pkg::DIV_N_W;
  localparam int DW    = hsps_pkg::DIV_D_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo;
  logic [DW:0]      rem;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] count;
  logic             busy;

  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;
  logic          ge;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign rem_sh = {rem[DW-1:0], quo[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};
  assign ge     = ~diff[DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NW);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DW:0] : rem_sh;
      quo <= {quo[NW-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/hsps_ctrl.sv =====
module hsps_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  hsps_pkg::hsps_stat_t   stat,
  output hsps_pkg::hsps_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_HOLD  = 3'd6;

  logic [2:0] state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_EVAL;
      ST_EVAL:  state_next = ST_PREP;
      ST_PREP:  state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (stat.div_done) state_next = ST_FIN;
      ST_FIN:   state_next = ST_HOLD;
      ST_HOLD:  if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = s_tvalid && (state == ST_IDLE);
    cmd.eval     = (state == ST_EVAL);
    cmd.prep     = (state == ST_PREP);
    cmd.start    = (state == ST_START);
    cmd.fin      = (state == ST_FIN);
    cmd.out_load = (state == ST_HOLD) && stat.out_free;
  end

endmodule

// ===== rtl/hsps_datapath.sv =====
module hsps_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  hsps_pkg::hsps_cmd_t    cmd,
  output hsps_pkg::hsps_stat_t   stat,
  input  logic [15:0]            s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [47:0]            m_tdata,
  output logic                   m_tuser,
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [19:0]            cfg_data
);

  localparam logic [2:0] CFG_DEBOUNCE = 3'd0;
  localparam logic [2:0] CFG_STEP     = 3'd1;
  localparam logic [2:0] CFG_TIMEOUT  = 3'd2;
  localparam logic [2:0] CFG_NUMER    = 3'd3;
  localparam logic [2:0] CFG_TPS      = 3'd4;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_ALL_LOW = 2'd1;
  localparam logic [1:0] ERR_SKIP    = 2'd2;
  localparam logic [1:0] ERR_SIGN    = 2'd3;

  localparam logic [12:0] FULL_TURN = 13'd3600;

  localparam int NW = hsps_pkg::DIV_N_W;
  localparam int DW = hsps_pkg::DIV_D_W;

  function automatic logic [2:0] hall_decode(input logic [2:0] pat);
    logic [2:0] s;
    case (pat)
      3'b001:  s = 3'd0;
      3'b101:  s = 3'd1;
      3'b100:  s = 3'd2;
      3'b110:  s = 3'd3;
      3'b010:  s = 3'd4;
      3'b011:  s = 3'd5;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // Halving that rounds toward zero.
  function automatic logic signed [15:0] half_tz(input logic signed [15:0] v);
    logic signed [16:0] w;
    w = $signed({v[15], v}) + $signed({16'd0, v[15]});
    return w[16:1];
  endfunction

  function automatic logic signed [15:0] avg_halves(input logic signed [15:0] a,
                                                    input logic signed [15:0] b);
    logic signed [16:0] w;
    w = $signed({a[15], a}) + $signed({b[15], b});
    return w[15:0];
  endfunction

  // Configuration registers.
  logic [7:0]  debounce_threshold;
  logic [9:0]  step_tenths;
  logic [15:0] timeout_ticks;
  logic [19:0] speed_numerator;
  logic [19:0] ticks_per_second;

  // Sample held for the evaluation step.
  logic [2:0]  pat;
  logic [9:0]  ticks;

  // Estimator state.
  logic [2:0]         accepted_sector;
  logic [2:0]         previous_sector;
  logic               seeded;
  logic [2:0]         candidate_sector;
  logic [2:0]         raw_sector;
  logic [7:0]         agree_count;
  logic [11:0]        position_acc;
  logic signed [15:0] speed_reg;
  logic [15:0]        step_timer;

  // Per-sample work registers.
  logic signed [3:0] dir;
  logic [1:0]        err;
  logic              stepped;

  // Result and output registers.
  logic [11:0] res_position, res_angle;
  logic [15:0] res_speed;
  logic [2:0]  res_sector;
  logic [1:0]  res_err;
  logic        res_stepped;
  logic [44:0] out_data;
  logic        out_stepped;
  logic        out_valid;

  // Divider.
  logic [NW-1:0] div_dividend, div_quotient;
  logic [DW-1:0] div_divisor;
  logic          div_done;

  hsps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_threshold <= 8'd25;
      step_tenths        <= 10'd75;
      timeout_ticks      <= 16'd30000;
      speed_numerator    <= 20'd62500;
      ticks_per_second   <= 20'd50000;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_threshold <= cfg_data[7:0];
        CFG_STEP:     step_tenths        <= cfg_data[9:0];
        CFG_TIMEOUT:  timeout_ticks      <= cfg_data[15:0];
        CFG_NUMER:    speed_numerator    <= cfg_data;
        CFG_TPS:      ticks_per_second   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pat   <= {s_tdata[0], s_tdata[1], s_tdata[2]};
      ticks <= s_tdata[12:3];
    end
  end

  // ---- Evaluation: timer, decode, debounce, direction, position ----
  logic [16:0]       timer_sum;
  logic [15:0]       timer_new;
  logic              pat_valid;
  logic [2:0]        raw_new, prev_eff, acc_eff, acc_new;
  logic [7:0]        agree_inc, agree_new;
  logic              agree_hit, agree_full;
  logic signed [3:0] diff, dir_new;
  logic [2:0]        mag;
  logic [12:0]       step_prod;
  logic [12:0]       delta;
  logic [12:0]       pos_fwd_sum, pos_bwd_sum;
  logic [11:0]       pos_fwd, pos_bwd;
  logic [1:0]        err_new;

  always_comb begin
    timer_sum  = {1'b0, step_timer} + {7'd0, ticks};
    timer_new  = timer_sum[16] ? 16'hFFFF : timer_sum[15:0];
    pat_valid  = (pat != 3'b000) && (pat != 3'b111);
    raw_new    = pat_valid ? hall_decode(pat) : raw_sector;
    prev_eff   = seeded ? previous_sector : raw_new;
    acc_eff    = seeded ? accepted_sector : raw_new;
    agree_inc  = agree_count + 8'd1;
    agree_hit  = (raw_new != prev_eff) && (raw_new == candidate_sector);
    agree_full = agree_inc >= debounce_threshold;
    agree_new  = (agree_hit && !agree_full) ? agree_inc : 8'd0;
    acc_new    = (agree_hit && agree_full) ? raw_new : acc_eff;
    diff       = $signed({1'b0, acc_new}) - $signed({1'b0, prev_eff});
    // A difference of five sectors is one step across the wrap.
    if (diff <= -4'sd5) begin
      dir_new = diff + 4'sd6;
    end else if (diff >= 4'sd5) begin
      dir_new = diff - 4'sd6;
    end else begin
      dir_new = diff;
    end
    mag         = dir_new[3] ? 3'(-dir_new) : dir_new[2:0];
    step_prod   = 13'(step_tenths * mag);
    delta       = (step_prod >= FULL_TURN) ? step_prod - FULL_TURN : step_prod;
    pos_fwd_sum = {1'b0, position_acc} + delta;
    pos_fwd     = 12'((pos_fwd_sum >= FULL_TURN) ? pos_fwd_sum - FULL_TURN : pos_fwd_sum);
    pos_bwd_sum = {1'b0, position_acc} + FULL_TURN - delta;
    pos_bwd     = 12'((pos_bwd_sum >= FULL_TURN) ? pos_bwd_sum - FULL_TURN : pos_bwd_sum);
    if ((dir_new <= -4'sd2) || (dir_new >= 4'sd2)) begin
      err_new = ERR_SKIP;
    end else if (pat == 3'b000) begin
      err_new = ERR_ALL_LOW;
    end else begin
      err_new = ERR_OK;
    end
  end

  // ---- Speed and interpolation ----
  logic signed [15:0] raw_hold;
  logic [15:0]        speed_mag;
  logic [16:0]        speed_mag3;
  logic [15:0]        t_clamp, t_div;
  logic [15:0]        q16, s_step;
  logic signed [15:0] speed_step;
  logic [9:0]         off;
  logic [12:0]        ang_sum;
  logic signed [13:0] ang_dif;
  logic [11:0]        angle_new;

  always_comb begin
    raw_hold     = (step_timer > timeout_ticks) ? 16'sd0 : speed_reg;
    speed_mag    = speed_reg[15] ? 16'(-speed_reg) : speed_reg;
    speed_mag3   = {speed_mag, 1'b0} + {1'b0, speed_mag};
    t_clamp      = (step_timer > timeout_ticks) ? timeout_ticks : step_timer;
    t_div        = (t_clamp == 16'd0) ? 16'd1 : t_clamp;
    div_dividend = stepped ? NW'(speed_numerator) : NW'(speed_mag3 * step_timer);
    div_divisor  = stepped ? DW'(t_div)
                 : ((ticks_per_second == 20'd0) ? DW'(1) : ticks_per_second);

    q16        = div_quotient[15:0];
    s_step     = dir[3] ? 16'(-q16) : q16;
    speed_step = avg_halves(half_tz($signed(s_step)), half_tz(speed_reg));

    off = (div_quotient > NW'(step_tenths)) ? step_tenths : div_quotient[9:0];
    ang_sum = {1'b0, position_acc} + {3'd0, off};
    ang_dif = $signed({2'b00, position_acc}) - $signed({4'd0, off});
    if (!speed_reg[15] && (speed_reg != 16'sd0)) begin
      angle_new = 12'((ang_sum >= FULL_TURN) ? ang_sum - FULL_TURN : ang_sum);
    end else begin
      angle_new = ang_dif[13] ? 12'(ang_dif + $signed({1'b0, FULL_TURN})) : ang_dif[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_sector  <= '0;
      previous_sector  <= '0;
      seeded           <= 1'b0;
      candidate_sector <= '0;
      raw_sector       <= '0;
      agree_count      <= '0;
      position_acc     <= '0;
      speed_reg        <= '0;
      step_timer       <= '0;
    end else if (cmd.eval) begin
      step_timer       <= timer_new;
      raw_sector       <= raw_new;
      candidate_sector <= raw_new;
      seeded           <= 1'b1;
      agree_count      <= agree_new;
      accepted_sector  <= acc_new;
      previous_sector  <= (dir_new != 4'sd0) ? acc_new : prev_eff;
      if (dir_new > 4'sd0) begin
        position_acc <= pos_fwd;
      end else if (dir_new < 4'sd0) begin
        position_acc <= pos_bwd;
      end
    end else if (cmd.prep && !stepped) begin
      speed_reg <= avg_halves(half_tz(raw_hold), half_tz(speed_reg));
    end else if (cmd.fin && stepped) begin
      speed_reg  <= speed_step;
      step_timer <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      dir     <= dir_new;
      err     <= err_new;
      stepped <= (dir_new != 4'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_position <= position_acc;
      res_sector   <= accepted_sector;
      res_stepped  <= stepped;
      if (stepped) begin
        res_angle <= position_acc;
        res_speed <= speed_step;
        // A forward step whose speed wraps negative is a sign fault.
        res_err   <= (!dir[3] && s_step[15]) ? ERR_SIGN : err;
      end else begin
        res_angle <= angle_new;
        res_speed <= speed_reg;
        res_err   <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data    <= {res_err, res_sector, res_speed, res_angle, res_position};
      out_stepped <= res_stepped;
    end
  end

  assign m_tvalid      = out_valid;
  assign m_tdata       = {3'd0, out_data};
  assign m_tuser       = out_stepped;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || m_tready;

endmodule

// ===== rtl/hall_sector_position_speed_core.sv =====
// Hall sensor position and speed estimator. Each input beat carries the three hall levels
// and the timer ticks since the previous sample; each one yields exactly one output beat
// with position, interpolated angle, filtered speed, accepted sector and error code, and
// tuser high when a sector step was taken. A sample holds the input closed from acceptance
// until its result moves to the output register; in that span the shared 33-step
// restoring divider forms either the step speed or the interpolation offset. The
// next sample may be accepted while the previous result still waits on the output.
// Configuration writes are always ready and take effect at once.
module hall_sector_position_speed_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // hall_a, hall_b, hall_c, ticks_elapsed[9:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // position[11:0], angle[11:0], speed[15:0], sector[2:0],
                                 // error_code[1:0]
  output logic        m_tuser,   // stepped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  hsps_pkg::hsps_cmd_t  cmd;
  hsps_pkg::hsps_stat_t stat;

  assign cfg_ready = 1'b1;

  hsps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hsps_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== rtl/hsps_checker.sv =====
module hsps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  // One sample at a time: an accepted beat closes the input until its work is done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a sample is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:0] < 12'd3600) && (m_tdata[23:12] < 12'd3600)
                 && (m_tdata[42:40] <= 3'd5))
    else $error("position, angle or sector out of range");

  // On a step the angle is snapped to the position.
  a_step_angle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[23:12] == m_tdata[11:0])
    else $error("angle differs from position on a step");

endmodule

bind hall_sector_position_speed_core hsps_checker u_hsps_checker (.*);
